/* hw/rtl/trapezoid_speed_profile_core_defines.svh */
// ----------------------------------------------------------------------------
// Trapezoid speed profile: assertion macros
// Shared check macros; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_SPEED_PROFILE_CORE_DEFINES_SVH
`define TRAPEZOID_SPEED_PROFILE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// check sampled on the rising edge, switched off while reset is high
`define TSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check sampled on the rising edge at all times
`define TSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSP_ASSERT(lbl, clk, rst, prop, msg)
`define TSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// Trapezoid speed profile: package
// Widths, register indexes and the stage payload types.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int FRACTION_BITS_DEF = 8;
   localparam int RATE_FRAC         = 16;
   localparam int SPEED_W           = 18;
   localparam int RATE_W            = 24;
   localparam int DIST_W            = 24;
   localparam int MARGIN_W          = 23;
   localparam int TIME_W            = 20;
   localparam int OUT_W             = 19;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 24;
   localparam int AOP_W             = DIST_W + 1;
   localparam int DOP_W             = DIST_W + 2;
   localparam int APROD_W           = RATE_W + AOP_W;
   localparam int DPROD_W           = RATE_W + DOP_W;
   localparam int RAMP_W            = SPEED_W + 1;

   localparam logic [SPEED_W-1:0] MAX_SPEED_RST = SPEED_W'(153600);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_SPEED        = 3'd0,
      REG_MAX_SPEED        = 3'd1,
      REG_ACC_RATE         = 3'd2,
      REG_DEC_RATE         = 3'd3,
      REG_TARGET_DISTANCE  = 3'd4,
      REG_MARGIN           = 3'd5,
      REG_TIME_BASED_ACCEL = 3'd6,
      REG_STOP_AT_END      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SPEED_W-1:0]       min_speed;
      logic [SPEED_W-1:0]       max_speed;
      logic [RATE_W-1:0]        acc_rate;
      logic [RATE_W-1:0]        dec_rate;
      logic signed [DIST_W-1:0] target_distance;
      logic [MARGIN_W-1:0]      margin;
      logic                     time_based_accel;
      logic                     stop_at_end;
   } cfg_type;

   // end-of-move decisions, worked out in the first stage and carried along
   typedef struct packed {
      logic backwards;
      logic force_lo;
      logic overshoot;
      logic rem_neg;
      logic rem_zero;
      logic in_margin;
   } flags_type;

   typedef struct packed {
      flags_type        flags;
      logic             a_time;
      logic             a_pos;
      logic [AOP_W-1:0] a_op;
      logic             d_pos;
      logic [DOP_W-1:0] d_op;
   } s1_type;

   typedef struct packed {
      flags_type          flags;
      logic               a_time;
      logic               a_pos;
      logic [APROD_W-1:0] a_prod;
      logic               d_pos;
      logic [DPROD_W-1:0] d_prod;
   } s2_type;

   typedef struct packed {
      flags_type          flags;
      logic [SPEED_W-1:0] v;
   } s3_type;

endpackage

/* hw/rtl/trapezoid_speed_profile_core.sv */
// Trapezoid speed profile core. Each req beat (distance, elapsed time) gives
// one rsp beat with the commanded signed speed, through four register stages
// (operands, multiply, ramp and minimum, end-of-move and sign); one beat is
// taken every cycle while the output is not held. A held rsp beat holds the
// whole pipeline, so req_stall follows rsp_stall while a result is waiting.
// The user writes the registers through the csr port only while no beat is
// in flight; the block itself does not enforce it.
`include "trapezoid_speed_profile_core_defines.svh"
// ----------------------------------------------------------------------------
// Trapezoid speed profile: top level
// Configuration registers, pipeline control and the output stage.
// ----------------------------------------------------------------------------
module trapezoid_speed_profile_core #(
   parameter int FRACTION_BITS = tsp_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tsp_pkg::DIST_W-1:0]   req_current_distance,
   input  logic [tsp_pkg::TIME_W-1:0]          req_elapsed_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tsp_pkg::OUT_W-1:0]    rsp_speed,
   input  logic                                csr_write,
   input  logic [tsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int OW = tsp_pkg::OUT_W;

   tsp_pkg::cfg_type          cfg_ff;
   logic                      pipe_en;
   logic                      s1_valid;
   logic                      s2_valid;
   logic                      s3_valid;
   tsp_pkg::s1_type           s1_data;
   tsp_pkg::s2_type           s2_data;
   tsp_pkg::s3_type           s3_data;
   logic                      rsp_valid_ff;
   logic signed [OW-1:0]      rsp_speed_ff;
   logic signed [OW-1:0]      rsp_speed_in;
   logic signed [OW-1:0]      mag;
   logic signed [OW-1:0]      lo;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_speed        <= '0;
         cfg_ff.max_speed        <= tsp_pkg::MAX_SPEED_RST;
         cfg_ff.acc_rate         <= '0;
         cfg_ff.dec_rate         <= '0;
         cfg_ff.target_distance  <= '0;
         cfg_ff.margin           <= '0;
         cfg_ff.time_based_accel <= 1'b1;
         cfg_ff.stop_at_end      <= 1'b1;
      end else if (csr_write) begin
         unique case (tsp_pkg::csr_index_type'(csr_index))
            tsp_pkg::REG_MIN_SPEED: begin
               cfg_ff.min_speed <= csr_wdata[tsp_pkg::SPEED_W-1:0];
            end
            tsp_pkg::REG_MAX_SPEED: begin
               cfg_ff.max_speed <= csr_wdata[tsp_pkg::SPEED_W-1:0];
            end
            tsp_pkg::REG_ACC_RATE: begin
               cfg_ff.acc_rate <= csr_wdata[tsp_pkg::RATE_W-1:0];
            end
            tsp_pkg::REG_DEC_RATE: begin
               cfg_ff.dec_rate <= csr_wdata[tsp_pkg::RATE_W-1:0];
            end
            tsp_pkg::REG_TARGET_DISTANCE: begin
               cfg_ff.target_distance <= signed'(csr_wdata[tsp_pkg::DIST_W-1:0]);
            end
            tsp_pkg::REG_MARGIN: begin
               cfg_ff.margin <= csr_wdata[tsp_pkg::MARGIN_W-1:0];
            end
            tsp_pkg::REG_TIME_BASED_ACCEL: begin
               cfg_ff.time_based_accel <= csr_wdata[0];
            end
            tsp_pkg::REG_STOP_AT_END: begin
               cfg_ff.stop_at_end <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // the pipeline moves unless a finished beat is held at the output
   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;

   tsp_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_distance (req_current_distance),
      .in_time     (req_elapsed_time),
      .out_valid   (s1_valid),
      .out_data    (s1_data)
   );

   tsp_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .acc_rate  (cfg_ff.acc_rate),
      .dec_rate  (cfg_ff.dec_rate),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   tsp_ramp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ramp (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .cfg       (cfg_ff),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   // end of move, margin window and direction; magnitudes stay below 2^18,
   // so the signed result always fits without clipping
   always_comb begin
      lo  = OW'(signed'({1'b0, cfg_ff.min_speed}));
      mag = OW'(signed'({1'b0, s3_data.v}));
      if (s3_data.flags.overshoot) begin
         if (!cfg_ff.stop_at_end) begin
            mag = lo;
         end else if (s3_data.flags.rem_zero) begin
            mag = '0;
         end else if (s3_data.flags.rem_neg) begin
            mag = -lo;
         end else begin
            mag = lo;
         end
      end
      if (cfg_ff.stop_at_end && s3_data.flags.in_margin) begin
         mag = '0;
      end
      rsp_speed_in = s3_data.flags.backwards ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_speed_ff <= rsp_speed_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_speed = rsp_speed_ff;

   // checks
   `TSP_ASSERT(a_stage_advance, clock, reset, (s3_valid && pipe_en) |=> rsp_valid, "beat lost in the last stage")
   `TSP_ASSERT(a_fwd_no_stop_sign, clock, reset, (rsp_valid && !cfg_ff.stop_at_end && !cfg_ff.target_distance[tsp_pkg::DIST_W-1]) |-> !rsp_speed[OW-1], "negative speed on a forward move")
   `TSP_ASSERT(a_held_pipe, clock, reset, (rsp_valid && rsp_stall) |=> ($stable(s3_valid) && $stable(s1_valid)), "pipeline moved while the output was held")
   `TSP_ASSERT_ALWAYS(a_stall_cause, clock, req_stall |-> rsp_stall, "input stalled with no output back-pressure")

endmodule

/* hw/rtl/tsp_prep.sv */
// ----------------------------------------------------------------------------
// Trapezoid speed profile: operand stage
// Mirrors the distance, forms the ramp operands and the end-of-move flags.
// ----------------------------------------------------------------------------
module tsp_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  tsp_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   input  logic signed [tsp_pkg::DIST_W-1:0] in_distance,
   input  logic [tsp_pkg::TIME_W-1:0]        in_time,
   output logic                              out_valid,
   output tsp_pkg::s1_type                   out_data
);

   localparam int W = tsp_pkg::DIST_W + 3;

   logic                 valid_ff;
   tsp_pkg::s1_type      data_ff;
   tsp_pkg::s1_type      data_in;
   logic                 backwards;
   logic signed [W-1:0]  mdist;
   logic signed [W-1:0]  tgt;
   logic signed [W-1:0]  endv;
   logic signed [W-1:0]  xd;
   logic signed [W-1:0]  rem;
   logic signed [W-1:0]  rem_abs;
   logic                 d_pos;

   // mirror onto magnitudes for a negative goal
   always_comb begin
      backwards = cfg.target_distance[tsp_pkg::DIST_W-1];
      mdist     = backwards ? -W'(in_distance) : W'(in_distance);
      tgt       = backwards ? -W'(cfg.target_distance) : W'(cfg.target_distance);
      endv      = tgt - W'(signed'({1'b0, cfg.margin}));
      xd        = endv - mdist;
      rem       = tgt - mdist;
      rem_abs   = rem[W-1] ? -rem : rem;
      d_pos     = mdist > W'(0);

      data_in.flags.backwards = backwards;
      data_in.flags.force_lo  = !cfg.time_based_accel && !d_pos;
      data_in.flags.overshoot = mdist >= endv;
      data_in.flags.rem_neg   = rem[W-1];
      data_in.flags.rem_zero  = rem == W'(0);
      data_in.flags.in_margin = rem_abs < W'(signed'({1'b0, cfg.margin}));
      data_in.a_time          = cfg.time_based_accel;
      if (cfg.time_based_accel) begin
         data_in.a_pos = in_time != '0;
         data_in.a_op  = tsp_pkg::AOP_W'(in_time);
      end else begin
         data_in.a_pos = d_pos;
         data_in.a_op  = mdist[tsp_pkg::AOP_W-1:0];
      end
      data_in.d_pos = xd > W'(0);
      data_in.d_op  = xd[tsp_pkg::DOP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/tsp_mul.sv */
// ----------------------------------------------------------------------------
// Trapezoid speed profile: multiply stage
// Rate times operand for the ramp-up and ramp-down terms.
// ----------------------------------------------------------------------------
module tsp_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [tsp_pkg::RATE_W-1:0]     acc_rate,
   input  logic [tsp_pkg::RATE_W-1:0]     dec_rate,
   input  logic                           in_valid,
   input  tsp_pkg::s1_type                in_data,
   output logic                           out_valid,
   output tsp_pkg::s2_type                out_data
);

   logic            valid_ff;
   tsp_pkg::s2_type data_ff;
   tsp_pkg::s2_type data_in;

   always_comb begin
      data_in.flags  = in_data.flags;
      data_in.a_time = in_data.a_time;
      data_in.a_pos  = in_data.a_pos;
      data_in.d_pos  = in_data.d_pos;
      data_in.a_prod = tsp_pkg::APROD_W'(acc_rate) * tsp_pkg::APROD_W'(in_data.a_op);
      data_in.d_prod = tsp_pkg::DPROD_W'(dec_rate) * tsp_pkg::DPROD_W'(in_data.d_op);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/tsp_ramp.sv */
// ----------------------------------------------------------------------------
// Trapezoid speed profile: ramp stage
// Scales the products, adds the start speed and takes the least of the terms.
// ----------------------------------------------------------------------------
module tsp_ramp #(
   parameter int FRACTION_BITS = tsp_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  tsp_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   input  tsp_pkg::s2_type                in_data,
   output logic                           out_valid,
   output tsp_pkg::s3_type                out_data
);

   localparam int TIME_SHIFT = tsp_pkg::RATE_FRAC - FRACTION_BITS;
   localparam int RW         = tsp_pkg::RAMP_W;
   localparam int SW         = tsp_pkg::SPEED_W;
   localparam logic [RW-1:0] RAMP_TOP = RW'(1) << SW;

   logic                            valid_ff;
   tsp_pkg::s3_type                 data_ff;
   tsp_pkg::s3_type                 data_in;
   logic [tsp_pkg::APROD_W-1:0]     a_scaled;
   logic [tsp_pkg::DPROD_W-1:0]     d_scaled;
   logic [RW-1:0]                   ra;
   logic [RW-1:0]                   rd;
   logic [RW:0]                     up;
   logic [RW:0]                     down;
   logic [RW:0]                     best;

   // ramp terms clip at 2^18, above any cruise speed; a zero rate is immediate
   always_comb begin
      a_scaled = in_data.a_time ? (in_data.a_prod >> TIME_SHIFT)
                                : (in_data.a_prod >> tsp_pkg::RATE_FRAC);
      d_scaled = in_data.d_prod >> tsp_pkg::RATE_FRAC;

      if (!in_data.a_pos) begin
         ra = '0;
      end else if (cfg.acc_rate == '0 || a_scaled >= tsp_pkg::APROD_W'(RAMP_TOP)) begin
         ra = RAMP_TOP;
      end else begin
         ra = a_scaled[RW-1:0];
      end

      if (!in_data.d_pos) begin
         rd = '0;
      end else if (cfg.dec_rate == '0 || d_scaled >= tsp_pkg::DPROD_W'(RAMP_TOP)) begin
         rd = RAMP_TOP;
      end else begin
         rd = d_scaled[RW-1:0];
      end

      up   = (RW+1)'(cfg.min_speed) + (RW+1)'(ra);
      down = (RW+1)'(cfg.min_speed) + (RW+1)'(rd);
      best = (RW+1)'(cfg.max_speed);
      if (up < best) begin
         best = up;
      end
      if (down < best) begin
         best = down;
      end

      data_in.flags = in_data.flags;
      data_in.v     = in_data.flags.force_lo ? cfg.min_speed : best[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* tb/trapezoid_speed_profile_core_tb.sv */
// ----------------------------------------------------------------------------
// Trapezoid speed profile: regression testbench
// Drives distance/time beats through several register settings, predicts each
// commanded speed and checks every rsp beat in order against the prediction.
// ----------------------------------------------------------------------------
module trapezoid_speed_profile_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // speed predictor and store of expected speeds
   class speed_scoreboard;
      tsp_pkg::cfg_type                  cfg;
      logic signed [tsp_pkg::OUT_W-1:0]  expected_speeds[$];
      int                                mismatches;

      function new();
         cfg = '0;
         cfg.max_speed        = tsp_pkg::MAX_SPEED_RST;
         cfg.time_based_accel = 1'b1;
         cfg.stop_at_end      = 1'b1;
         mismatches = 0;
      endfunction

      // rate times operand, zero for a non-positive operand, huge for a zero rate
      function longint ramp_term(longint rate, longint x, int shift);
         if (x <= 0) return 0;
         if (rate == 0) return longint'(1) << 40;
         return (rate * x) >>> shift;
      endfunction

      function longint lesser(longint a, longint b);
         return (a < b) ? a : b;
      endfunction

      function logic signed [tsp_pkg::OUT_W-1:0] predict_speed(
            logic signed [tsp_pkg::DIST_W-1:0] distance, logic [tsp_pkg::TIME_W-1:0] ms);
         longint d, t, tgt, lo, hi, mg, end_pt, v, rem, up, arem;
         bit     backwards;
         d = longint'(distance);
         t = longint'(ms);
         backwards = cfg.target_distance < 0;
         tgt = backwards ? -longint'(cfg.target_distance) : longint'(cfg.target_distance);
         lo = longint'(cfg.min_speed);
         hi = longint'(cfg.max_speed);
         mg = longint'(cfg.margin);
         end_pt = tgt - mg;
         if (backwards) d = -d;
         if (!cfg.time_based_accel) begin
            if (d <= 0) begin
               v = lo;
            end else begin
               v = lesser(hi, lo + ramp_term(longint'(cfg.acc_rate), d, tsp_pkg::RATE_FRAC));
               v = lesser(v, lo + ramp_term(longint'(cfg.dec_rate), end_pt - d,
                                            tsp_pkg::RATE_FRAC));
            end
         end else begin
            up = lesser(lo + ramp_term(longint'(cfg.acc_rate), t,
                                       tsp_pkg::RATE_FRAC - tsp_pkg::FRACTION_BITS_DEF), hi);
            v = lesser(up, lo + ramp_term(longint'(cfg.dec_rate), end_pt - d,
                                          tsp_pkg::RATE_FRAC));
         end
         // end of move
         rem = tgt - d;
         if (d >= end_pt) begin
            if (cfg.stop_at_end) v = (rem > 0) ? lo : ((rem < 0) ? -lo : 0);
            else v = lo;
         end
         arem = (rem < 0) ? -rem : rem;
         if (cfg.stop_at_end && arem < mg) v = 0;
         if (backwards) v = -v;
         if (v > 262143) v = 262143;
         if (v < -262144) v = -262144;
         return v[tsp_pkg::OUT_W-1:0];
      endfunction

      function void note_beat(logic signed [tsp_pkg::DIST_W-1:0] distance,
                              logic [tsp_pkg::TIME_W-1:0] ms);
         expected_speeds.push_back(predict_speed(distance, ms));
      endfunction

      function void check_beat(logic signed [tsp_pkg::OUT_W-1:0] speed);
         logic signed [tsp_pkg::OUT_W-1:0] want;
         if (expected_speeds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat: speed %0d", speed);
            return;
         end
         want = expected_speeds.pop_front();
         if (speed !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("speed mismatch: expected %0d actual %0d", want, speed);
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [tsp_pkg::DIST_W-1:0]   req_current_distance = '0;
   logic [tsp_pkg::TIME_W-1:0]          req_elapsed_time = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [tsp_pkg::OUT_W-1:0]    rsp_speed;
   logic                                csr_write = 1'b0;
   logic [tsp_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [tsp_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   speed_scoreboard sb = new();
   bit  quiet = 1'b0;
   int  rsp_hold_left = 0;
   int  idle_cycles = 0;

   localparam int WATCHDOG_LIMIT = 5000;

   trapezoid_speed_profile_core DUT (.*);

   always #4 clock = ~clock;

   // note accepted req beats, check accepted rsp beats, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_beat(req_current_distance, req_elapsed_time);
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_speed);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("trapezoid_speed_profile_core regression: fail");
            $finish;
         end
      end
   end

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 7) == 0) rsp_hold_left <= $urandom_range(1, 19);
      end
   end

   // one register write; the caller drops csr_write after the last one
   task automatic write_reg(tsp_pkg::csr_index_type idx,
                            logic [tsp_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         tsp_pkg::REG_MIN_SPEED:
            sb.cfg.min_speed = data[tsp_pkg::SPEED_W-1:0];
         tsp_pkg::REG_MAX_SPEED:
            sb.cfg.max_speed = data[tsp_pkg::SPEED_W-1:0];
         tsp_pkg::REG_ACC_RATE:
            sb.cfg.acc_rate = data[tsp_pkg::RATE_W-1:0];
         tsp_pkg::REG_DEC_RATE:
            sb.cfg.dec_rate = data[tsp_pkg::RATE_W-1:0];
         tsp_pkg::REG_TARGET_DISTANCE:
            sb.cfg.target_distance = data[tsp_pkg::DIST_W-1:0];
         tsp_pkg::REG_MARGIN:
            sb.cfg.margin = data[tsp_pkg::MARGIN_W-1:0];
         tsp_pkg::REG_TIME_BASED_ACCEL:
            sb.cfg.time_based_accel = data[0];
         tsp_pkg::REG_STOP_AT_END:
            sb.cfg.stop_at_end = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one req beat, then an optional random gap
   task automatic send_beat(logic signed [tsp_pkg::DIST_W-1:0] distance,
                            logic [tsp_pkg::TIME_W-1:0] ms);
      int gap;
      req_valid <= 1'b1;
      req_current_distance <= distance;
      req_elapsed_time <= ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_speeds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic setup(logic [17:0] lo, logic [17:0] hi, logic [23:0] acc,
                        logic [23:0] dec, logic [23:0] tgt, logic [22:0] mg,
                        bit tmode, bit stop);
      write_reg(tsp_pkg::REG_MIN_SPEED, 24'(lo));
      write_reg(tsp_pkg::REG_MAX_SPEED, 24'(hi));
      write_reg(tsp_pkg::REG_ACC_RATE, acc);
      write_reg(tsp_pkg::REG_DEC_RATE, dec);
      write_reg(tsp_pkg::REG_TARGET_DISTANCE, tgt);
      write_reg(tsp_pkg::REG_MARGIN, 24'(mg));
      write_reg(tsp_pkg::REG_TIME_BASED_ACCEL, 24'(tmode));
      write_reg(tsp_pkg::REG_STOP_AT_END, 24'(stop));
      csr_write <= 1'b0;
   endtask

   function automatic logic [23:0] pick(logic [23:0] top, logic [23:0] typical);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return top;
         default: return 24'($urandom_range(0, 32'(typical)));
      endcase
   endfunction

   // mostly a sweep along the move, some near the stop point, some noise
   task automatic random_beat();
      longint tgt, d;
      logic [tsp_pkg::TIME_W-1:0] ms;
      tgt = longint'(sb.cfg.target_distance);
      if (tgt < 0) tgt = -tgt;
      case ($urandom_range(0, 9))
         0:       d = longint'($signed(24'($urandom)));
         1, 2:    d = tgt - longint'(sb.cfg.margin) + longint'($signed(11'($urandom)));
         default: d = longint'($urandom_range(0, 32'(tgt + tgt / 8 + 16)));
      endcase
      if (sb.cfg.target_distance < 0) d = -d;
      ms = ($urandom_range(0, 9) < 7) ? 20'($urandom_range(0, 4000)) : 20'($urandom);
      send_beat(d[tsp_pkg::DIST_W-1:0], ms);
   endtask

   initial begin
      logic signed [tsp_pkg::DIST_W-1:0] spots[6];
      int phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a few beats under the reset settings
      send_beat(24'sd0, 20'd0);
      send_beat(24'sh7FFFFF, 20'hFFFFF);
      send_beat(24'sh800000, 20'd1000);

      // directed: both modes and both stop choices, key points of the move
      for (int m = 0; m < 4; m++) begin
         drain();
         setup(18'd2560, 18'd51200, 24'd196608, 24'd131072,
               (m < 2) ? 24'd25600 : -24'sd25600, 23'd512, m[0], m[1]);
         spots = '{24'sd0, 24'sd6400, 24'sd25000, 24'sd25600, 24'sd30000, -24'sd100};
         foreach (spots[i])
            send_beat((m < 2) ? spots[i] : -spots[i], (i == 5) ? 20'hFFFFF : 20'(i * 50));
      end

      // random phases, the last with no idling
      for (phase = 0; phase < 12; phase++) begin
         drain();
         if (phase == 11) quiet = 1'b1;
         if (phase == 0)
            setup(18'h3FFFF, 18'h3FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 23'h7FFFFF,
                  1'b1, 1'b1);
         else if (phase == 1)
            setup(18'd0, 18'd0, 24'd0, 24'd0, 24'h800000, 23'd0, 1'b0, 1'b0);
         else
            setup(18'(pick(24'h3FFFF, 24'd30000)), 18'(pick(24'h3FFFF, 24'd200000)),
                  pick(24'hFFFFFF, 24'h100000), pick(24'hFFFFFF, 24'h100000),
                  ($urandom_range(0, 1) ? 24'($urandom_range(1000, 8388607))
                                        : -24'($urandom_range(1000, 8388607))),
                  23'(pick(24'h7FFFFF, 24'd4000)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
         for (int i = 0; i < 125; i++) begin
            if (phase == 3 && i == 60) begin
               // hold the sender until every expected speed is back
               req_valid <= 1'b0;
               @(posedge clock);
               while (sb.expected_speeds.size() != 0) @(posedge clock);
            end
            random_beat();
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.expected_speeds.size() == 0)
         $display("trapezoid_speed_profile_core regression: pass");
      else
         $display("trapezoid_speed_profile_core regression: fail");
      $finish;
   end

endmodule
